[design/assert_macros.svh]
// assertion macros shared by the design files
// no dependencies; define ASSERT_OFF to drop all checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLY(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed: same-cycle implication");
`define ASSERT_NEXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLY(lbl, clk, rst_n, a, c)
`define ASSERT_NEXT(lbl, clk, rst_n, a, c)
`endif
`endif

[design/lisl_pkg.sv]
// shared constants and types for the increasing-run length block
// no dependencies
package lisl_pkg;

  localparam int MAX_LEN_DEF     = 64;
  localparam int VALUE_WIDTH_DEF = 32;

  // what one cell shows its upper neighbor
  typedef struct packed {
    logic occ;  // cell holds a live tail
    logic ge;   // live tail is >= the incoming value
  } lisl_link_t;

endpackage

[design/lis_length_stream.sv]
// Streaming longest strictly increasing subsequence length, by patience sorting.
// Depends on lisl_pkg, lisl_cell and assert_macros.svh.
//
// Accepts one value per clock and returns one result per request, in the cycle after it is
// taken, through a single output register; the request channel stalls only while that
// register holds a result that the far side stalls. The rate is set by the row of MAX_LEN
// tail cells, which all compare the value against their tails in the same cycle, and by
// the OR of their compare flags that decides between replace and append. A request marked
// last gets the final length and clears the length and overflow state. The tail cells need
// no clearing after reset: only cells below the current length are ever looked at.
module lis_length_stream #(
  parameter int MAX_LEN     = lisl_pkg::MAX_LEN_DEF,
  parameter int VALUE_WIDTH = lisl_pkg::VALUE_WIDTH_DEF,
  parameter int LEN_W       = $clog2(MAX_LEN + 1)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [VALUE_WIDTH-1:0] in_value,
  input  logic                   in_last_item,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [LEN_W-1:0]       out_lis_length,
  output logic                   out_overflow,
  output logic                   out_end_of_sequence
);

  `include "assert_macros.svh"

  logic [LEN_W-1:0] len_r, len_nxt;
  logic             ovf_r, ovf_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [LEN_W-1:0] out_len_r;
  logic             out_ovf_r;
  logic             out_eos_r;

  lisl_pkg::lisl_link_t link [MAX_LEN];
  logic [MAX_LEN-1:0]   ge_vec;
  logic [MAX_LEN-1:0]   sel_vec;

  logic             accept;
  logic             full;
  logic             any_ge;
  logic [LEN_W-1:0] len_upd;
  logic             ovf_upd;

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
    lisl_pkg::lisl_link_t prev;
    if (i == 0) begin : g_first
      assign prev = '{occ: 1'b1, ge: 1'b0};
    end else begin : g_rest
      assign prev = link[i-1];
    end
    lisl_cell #(
      .INDEX      (i),
      .VALUE_WIDTH(VALUE_WIDTH),
      .LEN_W      (LEN_W)
    ) u_cell (
      .clk      (clk),
      .value    (in_value),
      .wr_en    (accept),
      .run_len  (len_r),
      .prev_link(prev),
      .link     (link[i]),
      .sel      (sel_vec[i])
    );
    assign ge_vec[i] = link[i].ge;
  end

  assign full    = len_r == LEN_W'(MAX_LEN);
  assign any_ge  = |ge_vec;
  assign len_upd = (!any_ge && !full) ? len_r + LEN_W'(1) : len_r;
  assign ovf_upd = ovf_r || (!any_ge && full);

  always_comb begin
    len_nxt       = len_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (accept) begin
      len_nxt       = in_last_item ? '0 : len_upd;
      ovf_nxt       = in_last_item ? 1'b0 : ovf_upd;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      len_r       <= len_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_len_r <= len_upd;
      out_ovf_r <= ovf_upd;
      out_eos_r <= in_last_item;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_lis_length      = out_len_r;
  assign out_overflow        = out_ovf_r;
  assign out_end_of_sequence = out_eos_r;

  `ASSERT_IMPLY(a_len_bound, clk, rst_n, 1'b1, len_r <= LEN_W'(MAX_LEN))
  `ASSERT_IMPLY(a_one_write, clk, rst_n, accept, $onehot0(sel_vec))
  `ASSERT_NEXT(a_last_clears, clk, rst_n, accept && in_last_item, len_r == '0 && !ovf_r)
  `ASSERT_IMPLY(a_ovf_full, clk, rst_n, out_valid_r && out_ovf_r,
                out_len_r == LEN_W'(MAX_LEN))

endmodule

[design/lisl_cell.sv]
// one tail cell of the patience-sorting chain
// depends on lisl_pkg
module lisl_cell #(
  parameter int INDEX       = 0,
  parameter int VALUE_WIDTH = lisl_pkg::VALUE_WIDTH_DEF,
  parameter int LEN_W       = 7
) (
  input  logic                   clk,
  input  logic [VALUE_WIDTH-1:0] value,
  input  logic                   wr_en,
  input  logic [LEN_W-1:0]       run_len,
  input  lisl_pkg::lisl_link_t   prev_link,
  output lisl_pkg::lisl_link_t   link,
  output logic                   sel
);

  logic [VALUE_WIDTH-1:0] tail_r;
  logic                   occ;
  logic                   ge;

  assign occ = LEN_W'(INDEX) < run_len;
  assign ge  = occ && ($signed(tail_r) >= $signed(value));

  assign link.occ = occ;
  assign link.ge  = ge;

  // first live tail >= value, or the first free slot when none is
  assign sel = !prev_link.ge && (occ ? ge : prev_link.occ);

  always_ff @(posedge clk) begin
    if (wr_en && sel) begin
      tail_r <= value;
    end
  end

endmodule
